FILE: design/cffba_pkg.sv
`timescale 1ns / 1ps
package cffba_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int ADDR_W     = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((ADDR_W + CNT_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ADDR_W + 2 * CNT_W + 7) / 8) * 8;
    localparam int STATUS_W    = 2;

    // config port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_DISK_SIZE = '0;
    localparam logic [CNT_W-1:0]     DISK_SIZE_RST = CNT_W'(MAX_BLOCKS);

    // request kinds
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_MARK,
        S_FREE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic             wr;        // disk_size written this cycle
        logic [CNT_W-1:0] eff_size;  // disk_size saturated to MAX_BLOCKS
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

FILE: design/cffba_ram.sv
`timescale 1ns / 1ps
module cffba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: design/cffba_apb.sv
`timescale 1ns / 1ps
module cffba_apb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [cffba_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [cffba_pkg::PDATA_W-1:0]  i_pwdata,
    output logic [cffba_pkg::PDATA_W-1:0]  o_prdata,
    output logic                           o_pready,
    output cffba_pkg::t_cfg                o_cfg
);
    import cffba_pkg::*;

    logic [CNT_W-1:0]     r_disk_size;
    logic [REG_IDX_W-1:0] s_idx;
    logic                 s_wr;

    assign s_idx    = i_paddr[PADDR_W-1:2];
    assign o_pready = 1'b1;
    assign s_wr     = i_psel && i_penable && i_pwrite && o_pready && (s_idx == REG_DISK_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_size <= DISK_SIZE_RST;
        end else if (s_wr) begin
            r_disk_size <= i_pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        o_cfg.wr       = s_wr;
        o_cfg.eff_size = (r_disk_size > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : r_disk_size;
        o_prdata       = (s_idx == REG_DISK_SIZE) ? PDATA_W'(r_disk_size) : '0;
    end

endmodule

FILE: design/cffba_ctrl.sv
`timescale 1ns / 1ps
module cffba_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cffba_pkg::t_cfg                 i_cfg,
    // request side
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  logic                            i_cmd,
    input  logic [cffba_pkg::ADDR_W-1:0]    i_start,
    input  logic [cffba_pkg::CNT_W-1:0]     i_len,
    // result side
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output logic [cffba_pkg::STATUS_W-1:0]  o_status,
    output logic [cffba_pkg::ADDR_W-1:0]    o_alloc_start,
    output logic [cffba_pkg::CNT_W-1:0]     o_used,
    output logic [cffba_pkg::CNT_W-1:0]     o_free,
    // map memory
    output cffba_pkg::t_ram_req             o_ram,
    input  logic                            i_ram_rdata
);
    import cffba_pkg::*;

    t_state r_state, n_state;

    logic [ADDR_W-1:0]   r_addr;    // sweep / issue / mark pointer
    logic [CNT_W-1:0]    r_left;    // entries still to issue or mark
    logic                r_dv;      // read data valid this cycle
    logic [ADDR_W-1:0]   r_didx;    // index of that read data
    logic                r_cmd;
    logic [CNT_W-1:0]    r_len;
    logic [CNT_W-1:0]    r_run;
    logic [ADDR_W-1:0]   r_where;
    logic [STATUS_W-1:0] r_status;
    logic [CNT_W-1:0]    r_used;

    logic                r_ovalid;
    logic [STATUS_W-1:0] r_ostatus;
    logic [ADDR_W-1:0]   r_ostart;
    logic [CNT_W-1:0]    r_oused;
    logic [CNT_W-1:0]    r_ofree;

    logic                s_accept;
    logic                s_range;
    logic [CNT_W-1:0]    s_run_inc;
    logic                s_found;
    logic [ADDR_W-1:0]   s_where;
    logic                s_drained;
    logic                s_load;

    assign s_accept  = i_req_valid && o_req_ready;
    assign s_range   = ((CNT_W + 1)'(i_start) + (CNT_W + 1)'(i_len)) >
                       (CNT_W + 1)'(i_cfg.eff_size);
    assign s_run_inc = r_run + CNT_W'(1);
    assign s_found   = r_dv && !i_ram_rdata && ((r_len == '0) || (s_run_inc >= r_len));
    assign s_drained = !r_dv && (r_left == '0);
    assign s_load    = !r_ovalid || i_res_ready;

    // run ends at r_didx, so it starts len-1 entries earlier
    always_comb begin
        if (r_len == '0) begin
            s_where = r_didx;
        end else begin
            s_where = ADDR_W'(CNT_W'(r_didx) + CNT_W'(1) - r_len);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_addr == ADDR_W'(MAX_BLOCKS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_accept) begin
                    if (i_cmd == CMD_ALLOC) begin
                        n_state = S_SEARCH;
                    end else if (s_range || (i_len == '0)) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_FREE;
                    end
                end
            end
            S_SEARCH: begin
                if (s_found) begin
                    n_state = (r_len == '0) ? S_RESP : S_MARK;
                end else if (s_drained) begin
                    n_state = S_RESP;
                end
            end
            S_MARK: begin
                if (r_left == CNT_W'(1)) n_state = S_RESP;
            end
            S_FREE: begin
                if (s_drained) n_state = S_RESP;
            end
            S_RESP: begin
                if (s_load) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
        if (i_cfg.wr) n_state = S_CLEAR;
    end

    // outputs
    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        o_ram.raddr = r_addr;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_addr;
        o_ram.wdata = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ram.we = 1'b1;
            end
            S_MARK: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = 1'b1;
            end
            S_FREE: begin
                // clear each entry in the cycle after it was read
                o_ram.we    = r_dv;
                o_ram.waddr = r_didx;
            end
            default: o_ram.we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_used <= '0;
            r_dv   <= 1'b0;
        end else if (i_cfg.wr) begin
            r_addr <= '0;
            r_used <= '0;
            r_dv   <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + ADDR_W'(1);
                end
                S_IDLE: begin
                    if (s_accept) begin
                        r_cmd    <= i_cmd;
                        r_len    <= i_len;
                        r_run    <= '0;
                        r_dv     <= 1'b0;
                        r_where  <= '0;
                        r_status <= ST_DONE;
                        if (i_cmd == CMD_ALLOC) begin
                            r_addr <= '0;
                            r_left <= i_cfg.eff_size;
                        end else begin
                            r_addr <= i_start;
                            r_left <= i_len;
                            if (s_range) r_status <= ST_RANGE;
                        end
                    end
                end
                S_SEARCH: begin
                    r_dv <= (r_left != '0);
                    if (r_dv) begin
                        r_run <= i_ram_rdata ? '0 : s_run_inc;
                    end
                    if (s_found) begin
                        // rewind to the run start for marking
                        r_where <= s_where;
                        r_addr  <= s_where;
                        r_left  <= r_len;
                    end else begin
                        if (r_left != '0) begin
                            r_addr <= r_addr + ADDR_W'(1);
                            r_left <= r_left - CNT_W'(1);
                            r_didx <= r_addr;
                        end
                        if (s_drained) r_status <= ST_NOSPACE;
                    end
                end
                S_MARK: begin
                    r_addr <= r_addr + ADDR_W'(1);
                    r_left <= r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) r_used <= r_used + r_len;
                end
                S_FREE: begin
                    if (r_left != '0) begin
                        r_addr <= r_addr + ADDR_W'(1);
                        r_left <= r_left - CNT_W'(1);
                        r_didx <= r_addr;
                    end
                    r_dv <= (r_left != '0);
                    if (r_dv && i_ram_rdata) r_used <= r_used - CNT_W'(1);
                end
                default: r_dv <= 1'b0;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_RESP) && s_load) begin
            r_ovalid <= 1'b1;
        end else if (i_res_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RESP) && s_load) begin
            r_ostatus <= r_status;
            r_ostart  <= (r_cmd == CMD_ALLOC) ? r_where : '0;
            r_oused   <= r_used;
            r_ofree   <= i_cfg.eff_size - r_used;
        end
    end

    assign o_res_valid   = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_alloc_start = r_ostart;
    assign o_used        = r_oused;
    assign o_free        = r_ofree;

endmodule

FILE: design/contiguous_first_fit_block_allocator.sv
`timescale 1ns / 1ps
// First-fit contiguous block allocator over an in-use bitmap.
//
// Requests come in on the s_* stream, one item per request: tuser holds the
// request kind (allocate or free), tdata holds the start block and length.
// Each request gives exactly one result item on the m_* stream carrying a
// status code, the granted start block and the used and free block counts.
// disk_size is set through the APB port at byte address 0.
//
// The map lives in a 1-bit wide RAM with a registered read port. An allocate
// scans the map one entry per cycle from block 0 (first fit) and then marks
// the run one entry per cycle. A free reads and clears one entry per cycle;
// an out-of-range or empty free skips the map. One request is in work at a
// time, so the rate is set by that scan.
//
// After reset, and after every disk_size write, a clearing pass writes all
// MAX_BLOCKS map entries to free with s_tready low.
// Results sit in an output register; while the receiver stalls it holds,
// and the next request can still be taken and worked on, waiting for the
// register before its own result is loaded.
module contiguous_first_fit_block_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config port
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [cffba_pkg::PADDR_W-1:0]      i_paddr,
    input  logic [cffba_pkg::PDATA_W-1:0]      i_pwdata,
    output logic [cffba_pkg::PDATA_W-1:0]      o_prdata,
    output logic                               o_pready,
    // request stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [cffba_pkg::IN_TDATA_W-1:0]   i_s_tdata,   // start_req, length
    input  logic                               i_s_tuser,   // cmd
    // result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [cffba_pkg::OUT_TDATA_W-1:0]  o_m_tdata,   // alloc_start, used, free
    output logic [cffba_pkg::STATUS_W-1:0]     o_m_tuser    // status
);
    import cffba_pkg::*;

    t_cfg              s_cfg;
    t_ram_req          s_ram;
    logic              s_rdata;
    logic [ADDR_W-1:0] s_alloc_start;
    logic [CNT_W-1:0]  s_used;
    logic [CNT_W-1:0]  s_free;

    cffba_apb u_apb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (s_cfg)
    );

    cffba_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (s_ram.we),
        .i_waddr (s_ram.waddr),
        .i_wdata (s_ram.wdata),
        .i_raddr (s_ram.raddr),
        .o_rdata (s_rdata)
    );

    cffba_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (s_cfg),
        .i_req_valid   (i_s_tvalid),
        .o_req_ready   (o_s_tready),
        .i_cmd         (i_s_tuser),
        .i_start       (i_s_tdata[ADDR_W-1:0]),
        .i_len         (i_s_tdata[ADDR_W+CNT_W-1:ADDR_W]),
        .o_res_valid   (o_m_tvalid),
        .i_res_ready   (i_m_tready),
        .o_status      (o_m_tuser),
        .o_alloc_start (s_alloc_start),
        .o_used        (s_used),
        .o_free        (s_free),
        .o_ram         (s_ram),
        .i_ram_rdata   (s_rdata)
    );

    assign o_m_tdata = OUT_TDATA_W'({s_free, s_used, s_alloc_start});

endmodule

FILE: design/cffba_chk.sv
`timescale 1ns / 1ps
module cffba_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [cffba_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input logic [cffba_pkg::STATUS_W-1:0]     o_m_tuser
);
    import cffba_pkg::*;

    // one request in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while another was in work");

    // a refused request never carries a start block
    a_refused_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ST_DONE)) |-> (o_m_tdata[ADDR_W-1:0] == '0))
        else $error("refused request reports a start block");

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind contiguous_first_fit_block_allocator cffba_chk u_chk (.*);

FILE: tb/contiguous_first_fit_block_allocator_test.sv
`timescale 1ns / 1ps
module contiguous_first_fit_block_allocator_test;
    import cffba_pkg::*;

    // ------------------------------------------------------------------
    // Item layouts
    //   request tdata : [7:0] start_req, [16:8] length, rest zero
    //   request tuser : cmd
    //   result tdata  : [7:0] alloc_start, [16:8] used_count, [25:17] free_count
    //   result tuser  : status
    // ------------------------------------------------------------------
    localparam logic [PADDR_W-1:0] DISK_SIZE_ADDR = {REG_DISK_SIZE, 2'b00};
    localparam int RANDOM_PER_PHASE = 128;
    localparam int DRAIN_EVERY      = 60;   // sender waits for all results this often
    localparam int SETTLE_CYCLES    = 2 * MAX_BLOCKS + 8;
    localparam int STALL_LIMIT      = 20 * MAX_BLOCKS;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   first;
        logic [CNT_W-1:0]    used_cnt;
        logic [CNT_W-1:0]    free_cnt;
    } t_result;

    // a run the sender was granted and may hand back later
    typedef struct {
        int unsigned first;
        int unsigned count;
    } t_run;

    // ------------------------------------------------------------------
    // Block map mirror: predicts each result from its own copy of the
    // in-use map and the disk size, and checks results in order.
    // ------------------------------------------------------------------
    class alloc_book;
        bit [MAX_BLOCKS-1:0] in_use;
        int unsigned         size_reg;
        int unsigned         used_n;
        t_result             expected_q[$];
        int unsigned         errors;

        function new();
            errors = 0;
            configure(int'(DISK_SIZE_RST));
        endfunction

        // a disk_size write wipes the map
        function void configure(int unsigned value);
            size_reg = value & 'h1FF;
            in_use   = '0;
            used_n   = 0;
        endfunction

        function int unsigned disk_blocks();
            return (size_reg > MAX_BLOCKS) ? MAX_BLOCKS : size_reg;
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        // accepted request -> expected result (also returned to the sender)
        function t_result note_request(logic cmd, logic [ADDR_W-1:0] first,
                                       logic [CNT_W-1:0] count);
            t_result     r;
            int unsigned sz;
            int unsigned run;
            int unsigned spot;
            bit          found;
            int unsigned k;
            sz       = disk_blocks();
            r.status = ST_DONE;
            r.first  = '0;
            if (cmd == CMD_ALLOC) begin
                run   = 0;
                spot  = 0;
                found = 1'b0;
                // first fit: lowest run of count free blocks inside the disk
                for (k = 0; k < sz && !found; k++) begin
                    if (in_use[k]) begin
                        run = 0;
                    end else if (count == 0) begin
                        spot  = k;
                        found = 1'b1;
                    end else begin
                        run++;
                        if (run >= count) begin
                            spot  = k + 1 - count;
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    for (k = 0; k < count; k++) in_use[spot + k] = 1'b1;
                    used_n  += count;
                    r.first  = ADDR_W'(spot);
                end else begin
                    r.status = ST_NOSPACE;
                end
            end else if (int'(first) + int'(count) > int'(sz)) begin
                r.status = ST_RANGE;
            end else begin
                // only blocks really in use move the counts
                for (k = 0; k < count; k++) begin
                    if (in_use[first + k]) begin
                        in_use[first + k] = 1'b0;
                        used_n--;
                    end
                end
            end
            r.used_cnt = CNT_W'(used_n);
            r.free_cnt = CNT_W'(sz - used_n);
            expected_q.push_back(r);
            return r;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("result item with no request pending: status %0d start %0d",
                       got.status, got.first);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status != want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.first != want.first) begin
                $error("alloc_start: expected %0d, got %0d", want.first, got.first);
                errors++;
            end
            if (got.used_cnt != want.used_cnt) begin
                $error("used_count: expected %0d, got %0d", want.used_cnt, got.used_cnt);
                errors++;
            end
            if (got.free_cnt != want.free_cnt) begin
                $error("free_count: expected %0d, got %0d", want.free_cnt, got.free_cnt);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_psel;
    logic                   i_penable;
    logic                   i_pwrite;
    logic [PADDR_W-1:0]     i_paddr;
    logic [PDATA_W-1:0]     i_pwdata;
    logic [PDATA_W-1:0]     o_prdata;
    logic                   o_pready;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;   // start_req, length
    logic                   i_s_tuser;   // cmd
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // alloc_start, used_count, free_count
    logic [STATUS_W-1:0]    o_m_tuser;   // status

    contiguous_first_fit_block_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    alloc_book   book = new();
    t_run        live_runs[$];
    bit          gaps_on = 1'b1;   // off for the second-to-last random phase only (disk size 256)
    int unsigned idle_cycles = 0;

    // disk sizes per random phase: smallest, saturating, empty and in-between
    int unsigned phase_sizes[10] = '{1, 7, 256, 511, 0, 100, 300, 37, 256, 129};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver: stalls about 22% of cycles while gaps are on
    always @(posedge i_clk) begin
        i_m_tready <= !gaps_on || ($urandom_range(99) >= 22);
    end

    // result monitor; values read here are the ones from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            book.check_result('{status:   o_m_tuser,
                                first:    o_m_tdata[ADDR_W-1:0],
                                used_cnt: o_m_tdata[ADDR_W +: CNT_W],
                                free_cnt: o_m_tdata[ADDR_W + CNT_W +: CNT_W]});
        end
    end

    // watchdog: any handshake or register access counts as progress
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_psel && i_penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("contiguous_first_fit_block_allocator test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // one request item; returns once accepted, with its predicted result
    task automatic send_request(input logic cmd, input int unsigned first,
                                input int unsigned count, output t_result want);
        while (gaps_on && $urandom_range(99) < 22) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= IN_TDATA_W'({CNT_W'(count), ADDR_W'(first)});
        do @(posedge i_clk); while (!o_s_tready);
        want = book.note_request(cmd, ADDR_W'(first), CNT_W'(count));
    endtask

    // sender holds off until every pending result is back
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (book.outstanding() != 0);
    endtask

    // disk_size write, only with the block idle; it wipes the map
    task automatic write_disk_size(input int unsigned value);
        wait_for_results();
        repeat (2) @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= DISK_SIZE_ADDR;
        i_pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        book.configure(value);
        live_runs.delete();
    endtask

    // Random mix: mostly allocate / hand back granted runs, some stray frees
    // (out of range, zero length, blocks never used) and oversized requests.
    task automatic random_item(input int unsigned sz);
        int unsigned pick;
        int unsigned len;
        int unsigned idx;
        t_run        run;
        t_result     want;
        pick = $urandom_range(99);
        if (pick >= 50 && pick < 85 && live_runs.size() != 0) begin
            idx = $urandom_range(live_runs.size() - 1);
            run = live_runs[idx];
            live_runs.delete(idx);
            send_request(CMD_FREE, run.first, run.count, want);
        end else if (pick >= 85 && pick < 95) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(15);
            send_request(CMD_FREE, $urandom_range(255), len, want);
        end else begin
            pick = $urandom_range(99);
            if (sz == 0 || pick < 4)
                len = (pick < 2) ? 0 : $urandom_range(511);
            else if (pick < 8)
                len = $urandom_range(511, sz);
            else if (pick < 16)
                len = $urandom_range(sz, 1);
            else
                len = $urandom_range((sz + 7) / 8, 1);
            send_request(CMD_ALLOC, $urandom_range(255), len, want);
            if (want.status == ST_DONE && len != 0)
                live_runs.push_back('{first: want.first, count: len});
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_result want;
        int      ph;
        int      n;
        i_rst_n    <= 1'b0;
        i_psel     <= 1'b0;
        i_penable  <= 1'b0;
        i_pwrite   <= 1'b0;
        i_paddr    <= '0;
        i_pwdata   <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= CMD_ALLOC;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, at the reset disk size of 256
        send_request(CMD_ALLOC, 0,   0,   want);  // zero length: first free block
        send_request(CMD_ALLOC, 0,   1,   want);
        send_request(CMD_ALLOC, 0,   256, want);  // whole disk, one block taken
        send_request(CMD_ALLOC, 255, 255, want);  // exactly fills the rest
        send_request(CMD_ALLOC, 0,   0,   want);  // zero length on a full disk
        send_request(CMD_ALLOC, 0,   1,   want);  // full disk
        send_request(CMD_FREE,  0,   256, want);  // whole disk back
        send_request(CMD_ALLOC, 0,   256, want);
        send_request(CMD_FREE,  255, 1,   want);  // last block
        send_request(CMD_FREE,  255, 2,   want);  // one past the end
        send_request(CMD_FREE,  10,  0,   want);  // zero-length free
        send_request(CMD_FREE,  255, 256, want);
        send_request(CMD_ALLOC, 0,   1,   want);  // only block 255 is free
        send_request(CMD_FREE,  0,   511, want);  // length beyond any disk
        send_request(CMD_ALLOC, 0,   511, want);  // longer than the disk
        send_request(CMD_FREE,  0,   256, want);
        send_request(CMD_ALLOC, 0,   3,   want);
        send_request(CMD_ALLOC, 0,   5,   want);
        send_request(CMD_FREE,  0,   3,   want);  // hole at the bottom
        send_request(CMD_ALLOC, 0,   4,   want);  // too big for the hole
        send_request(CMD_ALLOC, 0,   3,   want);  // fits the hole exactly
        send_request(CMD_FREE,  170, 85,  want);  // blocks never used
        send_request(CMD_FREE,  85,  170, want);

        for (ph = 0; ph < $size(phase_sizes); ph++) begin
            write_disk_size(phase_sizes[ph]);
            gaps_on = (phase_sizes[ph] != 256 || ph < 8);
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                random_item(book.disk_blocks());
                if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                    wait_for_results();
            end
        end
        gaps_on = 1'b1;

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (book.outstanding() != 0) begin
            $error("%0d expected results never arrived", book.outstanding());
            book.errors++;
        end
        if (book.errors == 0)
            $display("contiguous_first_fit_block_allocator test passed");
        else
            $display("contiguous_first_fit_block_allocator test failed");
        $finish;
    end

endmodule
